### hdl/worst_fit_load_distributor_top_assert.svh
// Assertion macros shared by the worst-fit load distributor modules.
`ifndef WORST_FIT_LOAD_DISTRIBUTOR_TOP_ASSERT_SVH
`define WORST_FIT_LOAD_DISTRIBUTOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WFLD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WFLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/wfld_pkg.sv
// Package: field widths, codes, FSM states and controller/datapath bundles.
package wfld_pkg;

    localparam int MODE_W  = 3;
    localparam int ID_W    = 16;
    localparam int AMT_W   = 16;
    localparam int STAT_W  = 2;
    localparam int STAMP_W = 32;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RM    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PLACE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STOP  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LIST  = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DUP  = 2'd3;

    // What a result transaction carries besides its status
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_HOST,
        KIND_PEND
    } kind_t;

    typedef enum logic [3:0] {
        CS_CLEAR,
        CS_IDLE,
        CS_MSCAN_GO,
        CS_MSCAN,
        CS_HOST_SET,
        CS_ASCAN_GO,
        CS_ASCAN,
        CS_LOAD,
        CS_COMMIT,
        CS_ADD_WR,
        CS_ROOM_RD,
        CS_ROOM_WR,
        CS_LIST_EVAL,
        CS_LIST_EMIT,
        CS_EMIT
    } state_t;

    typedef struct packed {
        logic              clear;
        logic              latch;
        logic              m_start;
        logic              a_start;
        logic              set_host;
        logic              m_kill;
        logic              load_ld;
        logic              use_old;
        logic              drop;
        logic              commit;
        logic              add_wr;
        logic              room_rd;
        logic              room_wr;
        logic              pend_load;
        logic              emit;
        logic              emit_last;
        logic [STAT_W-1:0] emit_status;
        kind_t             emit_kind;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic m_done;
        logic a_done;
        logic m_hit;
        logic m_free;
        logic best_vld;
        logic a_hit;
        logic a_free;
        logic o_vld;
        logic pend_vld;
        logic cnt_full;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic [ID_W-1:0]  ident;
        logic [AMT_W-1:0] room;
    } mach_rec_t;

endpackage

### hdl/worst_fit_load_distributor_top.sv
// Throughput: one transaction at a time; each serial pass over a table reads one entry a cycle.
// A finished result sits in an output register, so a new transaction may start meanwhile.
// Reset (synchronous, active low) empties the machine table, then clears the app table valid
// bits in a pass over every slot during which no transaction is accepted.
module worst_fit_load_distributor_top #(
    parameter int MACHINE_SLOTS = 16,
    parameter int APP_SLOTS     = 64,
    parameter int LIST_LIMIT    = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [wfld_pkg::MODE_W-1:0] s_mode,
    input  logic [wfld_pkg::ID_W-1:0]   s_machine_id,
    input  logic [wfld_pkg::ID_W-1:0]   s_app_id,
    input  logic [wfld_pkg::AMT_W-1:0]  s_amount,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [wfld_pkg::STAT_W-1:0] m_status,
    output logic [wfld_pkg::ID_W-1:0]   m_host_id,
    output logic [wfld_pkg::ID_W-1:0]   m_listed_app,
    output logic                        m_entry_valid,
    output logic                        m_last
);
    import wfld_pkg::*;

    cmd_t cmd;
    sts_t sts;

    wfld_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .sts     (sts),
        .cmd     (cmd)
    );

    wfld_dp #(
        .MACHINE_SLOTS (MACHINE_SLOTS),
        .APP_SLOTS     (APP_SLOTS),
        .LIST_LIMIT    (LIST_LIMIT)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_machine_id  (s_machine_id),
        .s_app_id      (s_app_id),
        .s_amount      (s_amount),
        .cmd           (cmd),
        .sts           (sts),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_host_id     (m_host_id),
        .m_listed_app  (m_listed_app),
        .m_entry_valid (m_entry_valid),
        .m_last        (m_last)
    );

endmodule

### hdl/wfld_dp.sv
// Datapath: machine and application tables, serial scans, output register.
module wfld_dp #(
    parameter int MACHINE_SLOTS = 16,
    parameter int APP_SLOTS     = 64,
    parameter int LIST_LIMIT    = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [wfld_pkg::ID_W-1:0]  s_machine_id,
    input  logic [wfld_pkg::ID_W-1:0]  s_app_id,
    input  logic [wfld_pkg::AMT_W-1:0] s_amount,
    input  wfld_pkg::cmd_t             cmd,
    output wfld_pkg::sts_t             sts,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [wfld_pkg::STAT_W-1:0] m_status,
    output logic [wfld_pkg::ID_W-1:0]  m_host_id,
    output logic [wfld_pkg::ID_W-1:0]  m_listed_app,
    output logic                       m_entry_valid,
    output logic                       m_last
);
    import wfld_pkg::*;

    localparam int MW = $clog2(MACHINE_SLOTS);
    localparam int AW = $clog2(APP_SLOTS);
    localparam int CW = $clog2(LIST_LIMIT + 1);
    localparam logic [MW-1:0] M_LAST = MW'(MACHINE_SLOTS - 1);
    localparam logic [AW-1:0] A_LAST = AW'(APP_SLOTS - 1);

    typedef struct packed {
        logic [ID_W-1:0]    ident;
        logic [AMT_W-1:0]   load;
        logic [MW-1:0]      host;
        logic [STAMP_W-1:0] stamp;
        logic               valid;
    } app_rec_t;

    // Latched operands
    logic [ID_W-1:0]    mid_reg, aid_reg;
    logic [AMT_W-1:0]   amt_reg, ld_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic [MW-1:0]      host_reg;

    // Machine table
    mach_rec_t                 mach_mem [MACHINE_SLOTS];
    logic [MACHINE_SLOTS-1:0]  mvalid_reg;
    mach_rec_t                 m_q;
    logic [MW-1:0]             m_rd_addr;
    logic                      m_wr_en;
    logic [MW-1:0]             m_wr_addr;
    mach_rec_t                 m_wr_data;
    logic [AMT_W:0]            room_sum;

    // Machine scan
    logic          m_run_reg, m_pv_reg, m_done_reg;
    logic [MW-1:0] m_idx_reg, m_pidx_reg;
    logic          m_hit_reg, m_free_reg, best_vld_reg;
    logic [MW-1:0] m_hit_slot_reg, m_free_slot_reg, best_slot_reg;
    logic [AMT_W-1:0] best_room_reg;
    logic [ID_W-1:0]  best_ident_reg;
    logic          m_cur_vld, m_cur_fit;

    // Application table
    app_rec_t      app_mem [APP_SLOTS];
    app_rec_t      a_q;
    logic          a_wr_en;
    logic [AW-1:0] a_wr_addr;
    app_rec_t      a_wr_data;
    logic [AW-1:0] clr_idx_reg;

    // Application scan
    logic          a_run_reg, a_pv_reg, a_done_reg;
    logic [AW-1:0] a_idx_reg, a_pidx_reg;
    logic          a_hit_reg, a_free_reg, o_vld_reg;
    logic [AW-1:0] a_hit_slot_reg, a_free_slot_reg, o_slot_reg;
    logic [AMT_W-1:0] a_hit_load_reg, o_load_reg;
    logic [MW-1:0]    a_hit_host_reg;
    logic [ID_W-1:0]  o_ident_reg;
    logic [STAMP_W-1:0] o_stamp_reg;
    logic          a_cand;

    // Listing state
    logic               pend_vld_reg;
    logic [ID_W-1:0]    pend_ident_reg;
    logic [STAMP_W-1:0] pend_stamp_reg;
    logic [AW-1:0]      pend_slot_reg;
    logic [CW-1:0]      cnt_reg;

    // Output register
    logic out_free;

    assign out_free = !m_valid || m_ready;

    // Operand registers
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            mid_reg <= s_machine_id;
            aid_reg <= s_app_id;
            amt_reg <= s_amount;
        end
        if (cmd.load_ld) begin
            ld_reg <= cmd.use_old ? o_load_reg : amt_reg;
        end
        if (cmd.set_host) begin
            host_reg <= m_hit_slot_reg;
        end
    end

    // Placement stamp counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stamp_reg <= '0;
        end else if (cmd.commit) begin
            stamp_reg <= stamp_reg + STAMP_W'(1);
        end
    end

    // Machine table write selection
    assign room_sum  = {1'b0, m_q.room} + {1'b0, a_hit_load_reg};
    assign m_rd_addr = cmd.room_rd ? a_hit_host_reg : m_idx_reg;

    always_comb begin
        m_wr_en   = 1'b0;
        m_wr_addr = m_free_slot_reg;
        m_wr_data = '{ident: mid_reg, room: amt_reg};
        if (cmd.add_wr) begin
            m_wr_en = 1'b1;
        end else if (cmd.commit) begin
            m_wr_en   = 1'b1;
            m_wr_addr = best_slot_reg;
            m_wr_data = '{ident: best_ident_reg, room: best_room_reg - ld_reg};
        end else if (cmd.room_wr) begin
            m_wr_en   = 1'b1;
            m_wr_addr = a_hit_host_reg;
            m_wr_data = '{ident: m_q.ident,
                          room: room_sum[AMT_W] ? {AMT_W{1'b1}} : room_sum[AMT_W-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (m_wr_en) begin
            mach_mem[m_wr_addr] <= m_wr_data;
        end
        m_q <= mach_mem[m_rd_addr];
    end

    // Machine valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= '0;
        end else if (cmd.add_wr) begin
            mvalid_reg[m_free_slot_reg] <= 1'b1;
        end else if (cmd.m_kill) begin
            mvalid_reg[m_hit_slot_reg] <= 1'b0;
        end
    end

    // Machine scan: one entry per cycle, evaluated on the registered read
    assign m_cur_vld = mvalid_reg[m_pidx_reg];
    assign m_cur_fit = m_cur_vld && (m_q.room != '0) && (m_q.room >= ld_reg) &&
                       (!best_vld_reg || (m_q.room > best_room_reg) ||
                        ((m_q.room == best_room_reg) && (m_q.ident < best_ident_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_run_reg    <= 1'b0;
            m_pv_reg     <= 1'b0;
            m_done_reg   <= 1'b0;
            m_idx_reg    <= '0;
            m_hit_reg    <= 1'b0;
            m_free_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
        end else begin
            m_pv_reg   <= m_run_reg;
            m_done_reg <= m_pv_reg && (m_pidx_reg == M_LAST);
            if (cmd.m_start) begin
                m_run_reg    <= 1'b1;
                m_idx_reg    <= '0;
                m_hit_reg    <= 1'b0;
                m_free_reg   <= 1'b0;
                best_vld_reg <= 1'b0;
            end else if (m_run_reg) begin
                m_idx_reg <= m_idx_reg + MW'(1);
                if (m_idx_reg == M_LAST) begin
                    m_run_reg <= 1'b0;
                end
            end
            if (m_pv_reg) begin
                if (!m_hit_reg && m_cur_vld && (m_q.ident == mid_reg)) begin
                    m_hit_reg <= 1'b1;
                end
                if (!m_free_reg && !m_cur_vld) begin
                    m_free_reg <= 1'b1;
                end
                if (m_cur_fit) begin
                    best_vld_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_pidx_reg <= m_idx_reg;
        if (m_pv_reg) begin
            if (!m_hit_reg && m_cur_vld && (m_q.ident == mid_reg)) begin
                m_hit_slot_reg <= m_pidx_reg;
            end
            if (!m_free_reg && !m_cur_vld) begin
                m_free_slot_reg <= m_pidx_reg;
            end
            if (m_cur_fit) begin
                best_slot_reg  <= m_pidx_reg;
                best_room_reg  <= m_q.room;
                best_ident_reg <= m_q.ident;
            end
        end
    end

    // Application table writes: clearing pass, drop or commit
    always_comb begin
        a_wr_en   = 1'b0;
        a_wr_addr = clr_idx_reg;
        a_wr_data = '0;
        if (cmd.clear) begin
            a_wr_en = 1'b1;
        end else if (cmd.drop) begin
            a_wr_en   = 1'b1;
            a_wr_addr = cmd.use_old ? o_slot_reg : a_hit_slot_reg;
        end else if (cmd.commit) begin
            a_wr_en   = 1'b1;
            a_wr_addr = cmd.use_old ? o_slot_reg : a_free_slot_reg;
            a_wr_data = '{ident: cmd.use_old ? o_ident_reg : aid_reg,
                          load:  ld_reg,
                          host:  best_slot_reg,
                          stamp: stamp_reg + STAMP_W'(1),
                          valid: 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (a_wr_en) begin
            app_mem[a_wr_addr] <= a_wr_data;
        end
        a_q <= app_mem[a_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
        end else if (cmd.clear) begin
            clr_idx_reg <= clr_idx_reg + AW'(1);
        end
    end

    // Oldest app on the selected host after the pending entry
    assign a_cand = a_q.valid && (a_q.host == host_reg) &&
                    (!pend_vld_reg || (a_q.stamp > pend_stamp_reg) ||
                     ((a_q.stamp == pend_stamp_reg) && (a_pidx_reg > pend_slot_reg))) &&
                    (!o_vld_reg || (a_q.stamp < o_stamp_reg));

    // Application scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_run_reg  <= 1'b0;
            a_pv_reg   <= 1'b0;
            a_done_reg <= 1'b0;
            a_idx_reg  <= '0;
            a_hit_reg  <= 1'b0;
            a_free_reg <= 1'b0;
            o_vld_reg  <= 1'b0;
        end else begin
            a_pv_reg   <= a_run_reg;
            a_done_reg <= a_pv_reg && (a_pidx_reg == A_LAST);
            if (cmd.a_start) begin
                a_run_reg  <= 1'b1;
                a_idx_reg  <= '0;
                a_hit_reg  <= 1'b0;
                a_free_reg <= 1'b0;
                o_vld_reg  <= 1'b0;
            end else if (a_run_reg) begin
                a_idx_reg <= a_idx_reg + AW'(1);
                if (a_idx_reg == A_LAST) begin
                    a_run_reg <= 1'b0;
                end
            end
            if (a_pv_reg) begin
                if (!a_hit_reg && a_q.valid && (a_q.ident == aid_reg)) begin
                    a_hit_reg <= 1'b1;
                end
                if (!a_free_reg && !a_q.valid) begin
                    a_free_reg <= 1'b1;
                end
                if (a_cand) begin
                    o_vld_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_pidx_reg <= a_idx_reg;
        if (a_pv_reg) begin
            if (!a_hit_reg && a_q.valid && (a_q.ident == aid_reg)) begin
                a_hit_slot_reg <= a_pidx_reg;
                a_hit_load_reg <= a_q.load;
                a_hit_host_reg <= a_q.host;
            end
            if (!a_free_reg && !a_q.valid) begin
                a_free_slot_reg <= a_pidx_reg;
            end
            if (a_cand) begin
                o_slot_reg  <= a_pidx_reg;
                o_load_reg  <= a_q.load;
                o_ident_reg <= a_q.ident;
                o_stamp_reg <= a_q.stamp;
            end
        end
    end

    // Pending listing entry and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_vld_reg <= 1'b0;
            cnt_reg      <= '0;
        end else if (cmd.set_host) begin
            pend_vld_reg <= 1'b0;
            cnt_reg      <= '0;
        end else if (cmd.pend_load) begin
            pend_vld_reg <= 1'b1;
            cnt_reg      <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pend_load) begin
            pend_ident_reg <= o_ident_reg;
            pend_stamp_reg <= o_stamp_reg;
            pend_slot_reg  <= o_slot_reg;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.emit) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_status      <= cmd.emit_status;
            m_host_id     <= (cmd.emit_kind == KIND_HOST) ? best_ident_reg : '0;
            m_listed_app  <= (cmd.emit_kind == KIND_PEND) ? pend_ident_reg : '0;
            m_entry_valid <= (cmd.emit_kind == KIND_PEND);
            m_last        <= cmd.emit_last;
        end
    end

    // Status toward the controller
    always_comb begin
        sts.clr_done = cmd.clear && (clr_idx_reg == A_LAST);
        sts.m_done   = m_done_reg;
        sts.a_done   = a_done_reg;
        sts.m_hit    = m_hit_reg;
        sts.m_free   = m_free_reg;
        sts.best_vld = best_vld_reg;
        sts.a_hit    = a_hit_reg;
        sts.a_free   = a_free_reg;
        sts.o_vld    = o_vld_reg;
        sts.pend_vld = pend_vld_reg;
        sts.cnt_full = ((CW+1)'(cnt_reg) + (CW+1)'(1)) == (CW+1)'(LIST_LIMIT);
        sts.out_free = out_free;
    end

`include "worst_fit_load_distributor_top_assert.svh"
    `WFLD_ASSERT_NOW(a_emit_free, cmd.emit, !m_valid || m_ready, "result overwrites held transaction")
    `WFLD_ASSERT_NEXT(a_mdone_pulse, m_done_reg, !m_done_reg, "machine scan done held twice")
    `WFLD_ASSERT_NOW(a_commit_best, cmd.commit, best_vld_reg, "commit without chosen machine")

endmodule

### hdl/wfld_ctrl.sv
// Controller: operation sequencing state machine.
module wfld_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [wfld_pkg::MODE_W-1:0] s_mode,
    input  wfld_pkg::sts_t              sts,
    output wfld_pkg::cmd_t              cmd
);
    import wfld_pkg::*;

    state_t              state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic                chose_reg, chose_next;
    logic [STAT_W-1:0]   st_reg, st_next;
    kind_t               kind_reg, kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_CLEAR;
            mode_reg  <= MODE_ADD;
            chose_reg <= 1'b0;
            st_reg    <= STAT_OK;
            kind_reg  <= KIND_NONE;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            chose_reg <= chose_next;
            st_reg    <= st_next;
            kind_reg  <= kind_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        chose_next = chose_reg;
        st_next    = st_reg;
        kind_next  = kind_reg;
        case (state_reg)
            CS_CLEAR: begin
                if (sts.clr_done) begin
                    state_next = CS_IDLE;
                end
            end
            CS_IDLE: begin
                if (s_valid) begin
                    mode_next  = s_mode;
                    chose_next = 1'b0;
                    kind_next  = KIND_NONE;
                    case (s_mode)
                        MODE_ADD, MODE_RM, MODE_LIST: state_next = CS_MSCAN_GO;
                        MODE_PLACE, MODE_STOP:        state_next = CS_ASCAN_GO;
                        default: begin
                            st_next    = STAT_MISS;
                            state_next = CS_EMIT;
                        end
                    endcase
                end
            end
            CS_MSCAN_GO: state_next = CS_MSCAN;
            CS_MSCAN: begin
                if (sts.m_done) begin
                    if (chose_reg) begin
                        if (sts.best_vld) begin
                            state_next = CS_COMMIT;
                        end else if (mode_reg == MODE_PLACE) begin
                            st_next    = STAT_MISS;
                            state_next = CS_EMIT;
                        end else begin
                            state_next = CS_ASCAN_GO;
                        end
                    end else begin
                        case (mode_reg)
                            MODE_ADD: begin
                                if (sts.m_hit) begin
                                    st_next    = STAT_DUP;
                                    state_next = CS_EMIT;
                                end else if (!sts.m_free) begin
                                    st_next    = STAT_FULL;
                                    state_next = CS_EMIT;
                                end else begin
                                    state_next = CS_ADD_WR;
                                end
                            end
                            MODE_RM, MODE_LIST: begin
                                if (!sts.m_hit) begin
                                    st_next    = STAT_MISS;
                                    state_next = CS_EMIT;
                                end else begin
                                    state_next = CS_HOST_SET;
                                end
                            end
                            default: begin
                                st_next    = STAT_MISS;
                                state_next = CS_EMIT;
                            end
                        endcase
                    end
                end
            end
            CS_HOST_SET: state_next = CS_ASCAN_GO;
            CS_ASCAN_GO: state_next = CS_ASCAN;
            CS_ASCAN: begin
                if (sts.a_done) begin
                    case (mode_reg)
                        MODE_PLACE: begin
                            if (sts.a_hit) begin
                                st_next    = STAT_DUP;
                                state_next = CS_EMIT;
                            end else if (!sts.a_free) begin
                                st_next    = STAT_FULL;
                                state_next = CS_EMIT;
                            end else begin
                                state_next = CS_LOAD;
                            end
                        end
                        MODE_STOP: begin
                            if (!sts.a_hit) begin
                                st_next    = STAT_MISS;
                                state_next = CS_EMIT;
                            end else begin
                                state_next = CS_ROOM_RD;
                            end
                        end
                        MODE_RM: begin
                            if (!sts.o_vld) begin
                                st_next    = STAT_OK;
                                state_next = CS_EMIT;
                            end else begin
                                state_next = CS_LOAD;
                            end
                        end
                        MODE_LIST: state_next = CS_LIST_EVAL;
                        default: begin
                            st_next    = STAT_MISS;
                            state_next = CS_EMIT;
                        end
                    endcase
                end
            end
            CS_LOAD: begin
                chose_next = 1'b1;
                state_next = CS_MSCAN_GO;
            end
            CS_COMMIT: begin
                if (mode_reg == MODE_PLACE) begin
                    st_next    = STAT_OK;
                    kind_next  = KIND_HOST;
                    state_next = CS_EMIT;
                end else begin
                    state_next = CS_ASCAN_GO;
                end
            end
            CS_ADD_WR: begin
                st_next    = STAT_OK;
                state_next = CS_EMIT;
            end
            CS_ROOM_RD: state_next = CS_ROOM_WR;
            CS_ROOM_WR: begin
                st_next    = STAT_OK;
                state_next = CS_EMIT;
            end
            CS_LIST_EVAL: begin
                st_next = STAT_OK;
                if (sts.o_vld) begin
                    if (sts.pend_vld) begin
                        state_next = CS_LIST_EMIT;
                    end else if (sts.cnt_full) begin
                        kind_next  = KIND_PEND;
                        state_next = CS_EMIT;
                    end else begin
                        state_next = CS_ASCAN_GO;
                    end
                end else begin
                    kind_next  = sts.pend_vld ? KIND_PEND : KIND_NONE;
                    state_next = CS_EMIT;
                end
            end
            CS_LIST_EMIT: begin
                if (sts.out_free) begin
                    if (sts.cnt_full) begin
                        kind_next  = KIND_PEND;
                        state_next = CS_EMIT;
                    end else begin
                        state_next = CS_ASCAN_GO;
                    end
                end
            end
            CS_EMIT: begin
                if (sts.out_free) begin
                    state_next = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        cmd             = '0;
        cmd.emit_kind   = KIND_NONE;
        cmd.emit_status = STAT_OK;
        cmd.use_old     = (mode_reg == MODE_RM);
        s_ready         = 1'b0;
        case (state_reg)
            CS_CLEAR:    cmd.clear = 1'b1;
            CS_IDLE: begin
                s_ready   = 1'b1;
                cmd.latch = s_valid;
            end
            CS_MSCAN_GO: cmd.m_start = 1'b1;
            CS_ASCAN_GO: cmd.a_start = 1'b1;
            CS_HOST_SET: begin
                cmd.set_host = 1'b1;
                cmd.m_kill   = (mode_reg == MODE_RM);
            end
            CS_LOAD: begin
                cmd.load_ld = 1'b1;
                cmd.drop    = (mode_reg == MODE_RM);
            end
            CS_COMMIT:   cmd.commit = 1'b1;
            CS_ADD_WR:   cmd.add_wr = 1'b1;
            CS_ROOM_RD: begin
                cmd.room_rd = 1'b1;
                cmd.drop    = 1'b1;
            end
            CS_ROOM_WR:  cmd.room_wr = 1'b1;
            CS_LIST_EVAL: cmd.pend_load = sts.o_vld && !sts.pend_vld;
            CS_LIST_EMIT: begin
                cmd.emit      = sts.out_free;
                cmd.pend_load = sts.out_free;
                cmd.emit_kind = KIND_PEND;
            end
            CS_EMIT: begin
                cmd.emit        = sts.out_free;
                cmd.emit_last   = 1'b1;
                cmd.emit_status = st_reg;
                cmd.emit_kind   = kind_reg;
            end
            default: cmd = '0;
        endcase
    end

`include "worst_fit_load_distributor_top_assert.svh"
    `WFLD_ASSERT_NEXT(a_take_leaves, (state_reg == CS_IDLE) && s_valid, state_reg != CS_IDLE, "accepted transaction not started")
    `WFLD_ASSERT_NOW(a_scan_excl, cmd.m_start || cmd.a_start, !cmd.emit && !cmd.commit, "scan start collides with write or result")

endmodule

### tb/wfld_checker.sv
// Checker for the worst-fit load distributor: watches both channels, predicts results, compares.
`timescale 1ns / 100ps
module wfld_checker #(
    parameter int MACHINE_SLOTS = 16,
    parameter int APP_SLOTS     = 64,
    parameter int LIST_LIMIT    = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [wfld_pkg::MODE_W-1:0] s_mode,
    input  logic [wfld_pkg::ID_W-1:0]   s_machine_id,
    input  logic [wfld_pkg::ID_W-1:0]   s_app_id,
    input  logic [wfld_pkg::AMT_W-1:0]  s_amount,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [wfld_pkg::STAT_W-1:0] m_status,
    input  logic [wfld_pkg::ID_W-1:0]   m_host_id,
    input  logic [wfld_pkg::ID_W-1:0]   m_listed_app,
    input  logic                        m_entry_valid,
    input  logic                        m_last,
    output int                          err_count,
    output int                          pending
);
    import wfld_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   host;
        logic [ID_W-1:0]   app;
        logic              ent;
        logic              last;
    } outcome_t;

    outcome_t outcomes_due[$];

    // Shadow tables
    bit              mach_on   [MACHINE_SLOTS];
    logic [ID_W-1:0] mach_name [MACHINE_SLOTS];
    logic [15:0]     mach_room [MACHINE_SLOTS];
    bit              app_on    [APP_SLOTS];
    logic [ID_W-1:0] app_name  [APP_SLOTS];
    logic [15:0]     app_weight[APP_SLOTS];
    int              app_slot  [APP_SLOTS];
    logic [31:0]     app_order [APP_SLOTS];
    logic [31:0]     order_ctr;

    task automatic report_mismatch(input string what);
        $display("ERROR %0t: %s", $realtime, what);
        err_count++;
    endtask

    task automatic push_outcome(input logic [STAT_W-1:0] st, input logic [ID_W-1:0] h,
                                input logic [ID_W-1:0] ap, input logic ev, input logic lst);
        outcome_t o;
        o.status = st; o.host = h; o.app = ap; o.ent = ev; o.last = lst;
        outcomes_due = {outcomes_due, o};
    endtask

    function automatic int lookup_machine(input logic [ID_W-1:0] id);
        for (int m = 0; m < MACHINE_SLOTS; m++)
            if (mach_on[m] && mach_name[m] == id) return m;
        return -1;
    endfunction

    function automatic int lookup_app(input logic [ID_W-1:0] id);
        for (int a = 0; a < APP_SLOTS; a++)
            if (app_on[a] && app_name[a] == id) return a;
        return -1;
    endfunction

    // Worst fit: largest nonzero room that covers the load, ties to lowest id
    function automatic int roomiest_fit(input logic [15:0] load);
        int best;
        best = -1;
        for (int m = 0; m < MACHINE_SLOTS; m++) begin
            if (!mach_on[m] || mach_room[m] == 0 || mach_room[m] < load) continue;
            if (best < 0 || mach_room[m] > mach_room[best] ||
                (mach_room[m] == mach_room[best] && mach_name[m] < mach_name[best]))
                best = m;
        end
        return best;
    endfunction

    function automatic int host_app(input int a);
        int m;
        m = roomiest_fit(app_weight[a]);
        if (m < 0) return -1;
        order_ctr++;
        app_on[a] = 1;
        app_slot[a] = m;
        app_order[a] = order_ctr;
        mach_room[m] = mach_room[m] - app_weight[a];
        return m;
    endfunction

    // Oldest app on machine m after (ps, pa)
    function automatic int oldest_on(input int m, input bit first, input logic [31:0] ps,
                                     input int pa);
        int best;
        best = -1;
        for (int a = 0; a < APP_SLOTS; a++) begin
            if (!app_on[a] || app_slot[a] != m) continue;
            if (!first && (app_order[a] < ps || (app_order[a] == ps && a <= pa))) continue;
            if (best < 0 || app_order[a] < app_order[best]) best = a;
        end
        return best;
    endfunction

    task automatic predict_transaction(input logic [MODE_W-1:0] md, input logic [ID_W-1:0] mid,
                                       input logic [ID_W-1:0] aid, input logic [15:0] amt);
        int m, a, n, prev, dummy;
        logic [31:0] ps;
        logic [16:0] sum;
        case (md)
            MODE_ADD: begin
                if (lookup_machine(mid) >= 0) push_outcome(STAT_DUP, 0, 0, 0, 1);
                else begin
                    m = -1;
                    for (int i = MACHINE_SLOTS - 1; i >= 0; i--) if (!mach_on[i]) m = i;
                    if (m < 0) push_outcome(STAT_FULL, 0, 0, 0, 1);
                    else begin
                        mach_on[m] = 1; mach_name[m] = mid; mach_room[m] = amt;
                        push_outcome(STAT_OK, 0, 0, 0, 1);
                    end
                end
            end
            MODE_RM: begin
                m = lookup_machine(mid);
                if (m < 0) push_outcome(STAT_MISS, 0, 0, 0, 1);
                else begin
                    mach_on[m] = 0;
                    forever begin
                        a = oldest_on(m, 1, 0, 0);
                        if (a < 0) break;
                        app_on[a] = 0;
                        dummy = host_app(a);
                    end
                    push_outcome(STAT_OK, 0, 0, 0, 1);
                end
            end
            MODE_PLACE: begin
                if (lookup_app(aid) >= 0) push_outcome(STAT_DUP, 0, 0, 0, 1);
                else begin
                    a = -1;
                    for (int i = APP_SLOTS - 1; i >= 0; i--) if (!app_on[i]) a = i;
                    if (a < 0) push_outcome(STAT_FULL, 0, 0, 0, 1);
                    else begin
                        app_name[a] = aid; app_weight[a] = amt;
                        m = host_app(a);
                        if (m < 0) push_outcome(STAT_MISS, 0, 0, 0, 1);
                        else push_outcome(STAT_OK, mach_name[m], 0, 0, 1);
                    end
                end
            end
            MODE_STOP: begin
                a = lookup_app(aid);
                if (a < 0) push_outcome(STAT_MISS, 0, 0, 0, 1);
                else begin
                    m = app_slot[a];
                    sum = mach_room[m] + app_weight[a];
                    mach_room[m] = sum[16] ? 16'hFFFF : sum[15:0];
                    app_on[a] = 0;
                    push_outcome(STAT_OK, 0, 0, 0, 1);
                end
            end
            MODE_LIST: begin
                m = lookup_machine(mid);
                if (m < 0) push_outcome(STAT_MISS, 0, 0, 0, 1);
                else begin
                    n = 0; prev = 0; ps = 0;
                    while (n < LIST_LIMIT) begin
                        a = oldest_on(m, n == 0, ps, prev);
                        if (a < 0) break;
                        push_outcome(STAT_OK, 0, app_name[a], 1, 0);
                        ps = app_order[a]; prev = a; n++;
                    end
                    if (n == 0) push_outcome(STAT_OK, 0, 0, 0, 1);
                    else outcomes_due[$].last = 1;
                end
            end
            default: push_outcome(STAT_MISS, 0, 0, 0, 1);
        endcase
    endtask

    // Predict on input transactions, compare on output transactions
    always @(posedge aclk) begin
        outcome_t exp_o;
        if (!aresetn) begin
            for (int m = 0; m < MACHINE_SLOTS; m++) mach_on[m] = 0;
            for (int a = 0; a < APP_SLOTS; a++) app_on[a] = 0;
            order_ctr = 0;
            outcomes_due.delete();
            err_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (outcomes_due.size() == 0)
                    report_mismatch("unexpected result transaction");
                else begin
                    exp_o = outcomes_due.pop_front();
                    if (m_status !== exp_o.status)
                        report_mismatch($sformatf("status %0d exp %0d", m_status, exp_o.status));
                    if (m_host_id !== exp_o.host)
                        report_mismatch($sformatf("host %0d exp %0d", m_host_id, exp_o.host));
                    if (m_listed_app !== exp_o.app)
                        report_mismatch($sformatf("app %0d exp %0d", m_listed_app, exp_o.app));
                    if (m_entry_valid !== exp_o.ent)
                        report_mismatch($sformatf("entry %0b exp %0b", m_entry_valid, exp_o.ent));
                    if (m_last !== exp_o.last)
                        report_mismatch($sformatf("last %0b exp %0b", m_last, exp_o.last));
                end
            end
            if (s_valid && s_ready)
                predict_transaction(s_mode, s_machine_id, s_app_id, s_amount);
        end
        pending = outcomes_due.size();
    end
endmodule

### tb/tb_worst_fit_load_distributor_top.sv
// Testbench top: drives operations and result backpressure, reports the verdict.
`timescale 1ns / 100ps
module tb_worst_fit_load_distributor_top;
    import wfld_pkg::*;

    logic              aclk, aresetn;
    logic              s_valid, s_ready;
    logic [MODE_W-1:0] s_mode;
    logic [ID_W-1:0]   s_machine_id, s_app_id;
    logic [AMT_W-1:0]  s_amount;
    logic              m_valid, m_ready;
    logic [STAT_W-1:0] m_status;
    logic [ID_W-1:0]   m_host_id, m_listed_app;
    logic              m_entry_valid, m_last;
    int                err_count, pending;
    bit                quiet_tail, hold_sink;

    worst_fit_load_distributor_top dut (.*);

    wfld_checker chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        m_ready <= 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_sink) begin
                m_ready <= 0;
                for (n = 0; n < 800; n++) @(posedge aclk);
                hold_sink = 0;
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_ready <= 1;
                @(posedge aclk);
            end
        end
    end

    // Offer one operation and wait for acceptance
    task automatic send_op(input logic [MODE_W-1:0] md, input logic [ID_W-1:0] mid,
                           input logic [ID_W-1:0] aid, input logic [AMT_W-1:0] amt);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1; s_mode <= md; s_machine_id <= mid; s_app_id <= aid; s_amount <= amt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        logic [ID_W-1:0] pick;
        int r;
        aresetn <= 0; s_valid <= 0; s_mode <= 0; s_machine_id <= 0;
        s_app_id <= 0; s_amount <= 0;
        quiet_tail = 0; hold_sink = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1;

        // Directed: misses, duplicates, zero room, ties, table fill
        send_op(MODE_LIST, 16'h0005, 0, 0);
        send_op(MODE_RM, 16'hFFFF, 0, 0);
        send_op(MODE_STOP, 0, 16'hFFFF, 0);
        send_op(MODE_PLACE, 0, 16'h0001, 0);
        send_op(MODE_ADD, 16'h0000, 0, 16'h0000);
        send_op(MODE_PLACE, 0, 16'h0002, 0);
        send_op(MODE_ADD, 16'hFFFF, 0, 16'hFFFF);
        send_op(MODE_ADD, 16'h0007, 0, 16'hFFFF);
        send_op(MODE_ADD, 16'h0007, 0, 16'h0010);
        send_op(MODE_PLACE, 0, 16'h0003, 16'hFFFF);
        send_op(MODE_PLACE, 0, 16'h0003, 16'h0001);
        send_op(MODE_PLACE, 0, 16'hFFFF, 16'h0100);
        send_op(MODE_STOP, 0, 16'h0003, 0);
        send_op(MODE_LIST, 16'hFFFF, 0, 0);
        send_op(MODE_RM, 16'h0007, 0, 0);
        send_op(MODE_LIST, 16'hFFFF, 0, 0);
        send_op(3'd5, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_op(3'd7, 16'h5555, 16'hAAAA, 16'h5555);
        for (int i = 0; i < 15; i++) send_op(MODE_ADD, 16'(16'h0100 + i), 0, 16'h8000);
        drain_results();

        // Receiver hold-off while sender keeps offering, then a full pause
        hold_sink = 1;
        for (int i = 0; i < 64; i++) send_op(MODE_PLACE, 0, 16'(16'h2000 + i), 16'h0400);
        drain_results();
        for (int i = 0; i < 5; i++) send_op(MODE_LIST, 16'(16'h0100 + i), 0, 0);
        send_op(MODE_RM, 16'h0100, 0, 0);
        drain_results();

        // Random: small id pools so operations hit existing entries
        for (int i = 0; i < 12; i++) begin
            if (i == 8) quiet_tail = 1;
            r = $urandom_range(0, 99);
            pick = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
            if (r < 15)      send_op(MODE_ADD, pick, 16'($urandom),
                                     ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                                 : 16'($urandom_range(0, 3000)));
            else if (r < 25) send_op(MODE_RM, pick, 16'($urandom), 16'($urandom));
            else if (r < 60) send_op(MODE_PLACE, 16'($urandom), pick,
                                     ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                                 : 16'($urandom_range(0, 600)));
            else if (r < 75) send_op(MODE_STOP, 16'($urandom), pick, 16'($urandom));
            else if (r < 95) send_op(MODE_LIST, pick, 16'($urandom), 16'($urandom));
            else             send_op(3'($urandom_range(5, 7)), 16'($urandom), 16'($urandom),
                                     16'($urandom));
        end
        drain_results();
        repeat (3000) @(posedge aclk);

        if (err_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### sim.f
+incdir+hdl
hdl/wfld_pkg.sv
hdl/wfld_dp.sv
hdl/wfld_ctrl.sv
hdl/worst_fit_load_distributor_top.sv
tb/wfld_checker.sv
tb/tb_worst_fit_load_distributor_top.sv
